FILE: design/bct_pkg.sv
// Shared constants, types and helpers for the box corner transform.
// No dependencies; every other file depends on this package.
package bct_pkg;

  localparam int COORD_W    = 32;
  localparam int COORD_FRAC = COORD_W / 2;
  localparam int ANGLE_W    = 16;
  localparam int ANGLE_FRAC = ANGLE_W - 2;
  localparam int TRIG_FRAC  = 30;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int N_TERMS    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int N_CORNERS  = 8;
  localparam int CIDX_W     = 3;

  localparam logic [MUL_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [MUL_W-1:0] TRIG_ONE    = 32'h4000_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // sine and cosine, signed Q2.30
  typedef struct packed {
    coord_t s;
    coord_t c;
  } trig_t;

  localparam longint TWO32 = 64'sd4294967296;

  // Taylor divisors (Horner order) and floor(2^32 / d) reciprocals
  localparam logic [7:0] SIN_DIV [N_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [N_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
  localparam logic [MUL_W-1:0] SIN_RECIP [N_TERMS] = '{
    32'(TWO32 / 110), 32'(TWO32 / 72), 32'(TWO32 / 42), 32'(TWO32 / 20), 32'(TWO32 / 6)};
  localparam logic [MUL_W-1:0] COS_RECIP [N_TERMS] = '{
    32'(TWO32 / 132), 32'(TWO32 / 90), 32'(TWO32 / 56), 32'(TWO32 / 30), 32'(TWO32 / 12)};

  // clamp a one-bit-wider sum into the coordinate range
  function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/bct_if.sv
// Handshake channels of the box corner transform: request, corner result, config.
// Depends on bct_pkg.
interface bct_in_if;
  logic            valid;
  logic            ready;
  bct_pkg::coord_t pos_x;
  bct_pkg::coord_t pos_y;
  bct_pkg::coord_t pos_z;
  bct_pkg::angle_t angle_x;
  bct_pkg::angle_t angle_y;
  bct_pkg::angle_t angle_z;
  bct_pkg::coord_t scale_x;
  bct_pkg::coord_t scale_y;
  bct_pkg::coord_t scale_z;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, output ready);
endinterface

interface bct_out_if;
  logic            valid;
  logic            ready;
  logic [2:0]      corner_index;
  bct_pkg::coord_t out_x;
  bct_pkg::coord_t out_y;
  bct_pkg::coord_t out_z;
  logic            from_cache;
  logic            last_corner;
  modport source (output valid, corner_index, out_x, out_y, out_z, from_cache,
                  last_corner, input ready);
  modport sink   (input valid, corner_index, out_x, out_y, out_z, from_cache,
                  last_corner, output ready);
endinterface

interface bct_cfg_if;
  logic              valid;
  logic              ready;
  bct_pkg::cfg_idx_t index;
  bct_pkg::coord_t   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bct_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on bct_pkg.
module bct_mul (
  input  logic                         clk,
  input  logic [bct_pkg::MUL_W-1:0]    a,
  input  logic [bct_pkg::MUL_W-1:0]    b,
  output logic [bct_pkg::PROD_W-1:0]   p
);
  import bct_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: design/bct_trig.sv
// Sine/cosine sequencer: Horner Taylor series on the shared multiplier.
// Depends on bct_pkg; product comes from bct_mul, registered, in the cycle after the operands.
module bct_trig (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  bct_pkg::angle_t             angle,
  output logic                        done,
  output bct_pkg::trig_t              res,
  output logic [bct_pkg::MUL_W-1:0]   mul_a,
  output logic [bct_pkg::MUL_W-1:0]   mul_b,
  input  logic [bct_pkg::PROD_W-1:0]  prod
);
  import bct_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE, T_X, T_X2, T_TM, T_DV, T_FX, T_S, T_TERM, T_MAP
  } tstate_t;

  tstate_t             state;
  logic                wb;
  logic                cosp;
  logic [2:0]          i;
  logic [ANGLE_FRAC-1:0] f;
  logic [1:0]          q;
  logic [MUL_W-1:0]    x;
  logic [MUL_W-1:0]    x2;
  logic [MUL_W-1:0]    t;
  logic [MUL_W-1:0]    v;
  logic [MUL_W-1:0]    qe;
  logic [MUL_W-1:0]    s_mag;
  logic [MUL_W-1:0]    c_mag;

  logic [PROD_W-1:0]   prod_sh;
  logic [MUL_W-1:0]    term;
  logic [7:0]          dcur;
  logic [MUL_W-1:0]    rcur;
  logic [MUL_W+7:0]    rem;
  logic [MUL_W-1:0]    qq;

  always_comb begin
    case (state)
      T_X:          begin mul_a = MUL_W'(f); mul_b = HALF_PI_Q30; end
      T_X2:         begin mul_a = x;         mul_b = x;           end
      T_TM, T_TERM: begin mul_a = x2;        mul_b = t;           end
      T_DV:         begin mul_a = v;         mul_b = rcur;        end
      T_S:          begin mul_a = x;         mul_b = t;           end
      default:      begin mul_a = '0;        mul_b = '0;          end
    endcase
  end

  assign dcur    = cosp ? COS_DIV[i] : SIN_DIV[i];
  assign rcur    = cosp ? COS_RECIP[i] : SIN_RECIP[i];
  assign prod_sh = prod >> TRIG_FRAC;
  assign term    = prod_sh[MUL_W:1];
  // reciprocal estimate is low by at most one
  assign rem     = (MUL_W+8)'(v) - (MUL_W+8)'(qe) * (MUL_W+8)'(dcur);
  assign qq      = qe + MUL_W'(rem >= (MUL_W+8)'(dcur));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      wb    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == T_MAP);
      case (state)
        T_IDLE: begin
          if (start) begin
            f     <= angle[ANGLE_FRAC-1:0];
            q     <= angle[ANGLE_W-1 -: 2];
            wb    <= 1'b0;
            state <= T_X;
          end
        end
        T_X: begin
          wb <= !wb;
          if (wb) begin
            x     <= MUL_W'(prod >> ANGLE_FRAC);
            state <= T_X2;
          end
        end
        T_X2: begin
          wb <= !wb;
          if (wb) begin
            x2    <= prod_sh[MUL_W-1:0];
            t     <= TRIG_ONE;
            i     <= '0;
            cosp  <= 1'b0;
            state <= T_TM;
          end
        end
        T_TM: begin
          wb <= !wb;
          if (wb) begin
            v     <= prod_sh[MUL_W-1:0];
            state <= T_DV;
          end
        end
        T_DV: begin
          wb <= !wb;
          if (wb) begin
            qe    <= prod[PROD_W-1:MUL_W];
            state <= T_FX;
          end
        end
        T_FX: begin
          t <= TRIG_ONE - qq;
          if (i == 3'(N_TERMS - 1)) begin
            state <= cosp ? T_TERM : T_S;
          end else begin
            i     <= i + 3'd1;
            state <= T_TM;
          end
        end
        T_S: begin
          wb <= !wb;
          if (wb) begin
            s_mag <= (prod_sh > PROD_W'(TRIG_ONE)) ? TRIG_ONE : prod_sh[MUL_W-1:0];
            t     <= TRIG_ONE;
            i     <= '0;
            cosp  <= 1'b1;
            state <= T_TM;
          end
        end
        T_TERM: begin
          wb <= !wb;
          if (wb) begin
            c_mag <= (term > TRIG_ONE) ? '0 : TRIG_ONE - term;
            state <= T_MAP;
          end
        end
        T_MAP: begin
          // quadrant fold
          case (q)
            2'd0:    begin res.s <= s_mag;           res.c <= c_mag;           end
            2'd1:    begin res.s <= c_mag;           res.c <= -$signed(s_mag); end
            2'd2:    begin res.s <= -$signed(s_mag); res.c <= -$signed(c_mag); end
            default: begin res.s <= -$signed(c_mag); res.c <= s_mag;           end
          endcase
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

FILE: design/bct_xform.sv
// Corner sequencer: scale, three rotations and translation of one corner,
// one product at a time on the shared multiplier. Depends on bct_pkg.
module bct_xform (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  bct_pkg::vec_t               box,
  input  bct_pkg::vec_t               scale,
  input  bct_pkg::vec_t               pos,
  input  bct_pkg::trig_t              rot_x,
  input  bct_pkg::trig_t              rot_y,
  input  bct_pkg::trig_t              rot_z,
  output logic                        done,
  output bct_pkg::vec_t               res,
  output logic [bct_pkg::MUL_W-1:0]   mul_a,
  output logic [bct_pkg::MUL_W-1:0]   mul_b,
  input  logic [bct_pkg::PROD_W-1:0]  prod
);
  import bct_pkg::*;

  typedef enum logic [3:0] {
    ST_VX, ST_VY, ST_VZ, ST_X1A, ST_X1, ST_Y1A, ST_Y1, ST_X2A, ST_X2,
    ST_Z2A, ST_Z2, ST_Y3A, ST_Y3, ST_Z3A, ST_Z3, ST_POS
  } step_t;

  step_t  op;
  logic   busy;
  logic   wb;
  coord_t acc, vx, vy, vz, x1, y1, x2, z2, y3, z3;

  coord_t              opa, opb;
  logic                frac16;
  logic                neg;
  logic [PROD_W-1:0]   shifted;
  logic [PROD_W-1:0]   cap;
  logic [PROD_W-1:0]   mag;
  coord_t              mres;
  coord_t              sum_add, sum_sub;

  always_comb begin
    frac16 = 1'b0;
    case (op)
      ST_VX:   begin opa = box.x; opb = scale.x;  frac16 = 1'b1; end
      ST_VY:   begin opa = box.y; opb = scale.y;  frac16 = 1'b1; end
      ST_VZ:   begin opa = box.z; opb = scale.z;  frac16 = 1'b1; end
      ST_X1A:  begin opa = vx;    opb = rot_z.c; end
      ST_X1:   begin opa = vy;    opb = rot_z.s; end
      ST_Y1A:  begin opa = vx;    opb = rot_z.s; end
      ST_Y1:   begin opa = vy;    opb = rot_z.c; end
      ST_X2A:  begin opa = x1;    opb = rot_y.c; end
      ST_X2:   begin opa = vz;    opb = rot_y.s; end
      ST_Z2A:  begin opa = vz;    opb = rot_y.c; end
      ST_Z2:   begin opa = x1;    opb = rot_y.s; end
      ST_Y3A:  begin opa = y1;    opb = rot_x.c; end
      ST_Y3:   begin opa = z2;    opb = rot_x.s; end
      ST_Z3A:  begin opa = y1;    opb = rot_x.s; end
      ST_Z3:   begin opa = z2;    opb = rot_x.c; end
      default: begin opa = '0;    opb = '0;      end
    endcase
  end

  // sign-magnitude product, truncated toward zero, clamped
  assign neg     = opa[COORD_W-1] ^ opb[COORD_W-1];
  assign mul_a   = opa[COORD_W-1] ? MUL_W'(-opa) : MUL_W'(opa);
  assign mul_b   = opb[COORD_W-1] ? MUL_W'(-opb) : MUL_W'(opb);
  assign shifted = frac16 ? (prod >> COORD_FRAC) : (prod >> TRIG_FRAC);
  assign cap     = (PROD_W'(1) << (COORD_W - 1)) - PROD_W'(!neg);
  assign mag     = (shifted > cap) ? cap : shifted;
  assign mres    = neg ? -coord_t'(mag[COORD_W-1:0]) : coord_t'(mag[COORD_W-1:0]);
  assign sum_add = sat_coord((COORD_W+1)'(acc) + (COORD_W+1)'(mres));
  assign sum_sub = sat_coord((COORD_W+1)'(acc) - (COORD_W+1)'(mres));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wb   <= 1'b0;
      done <= 1'b0;
      op   <= ST_VX;
    end else begin
      done <= busy && !start && (op == ST_POS);
      if (start) begin
        busy <= 1'b1;
        wb   <= 1'b0;
        op   <= ST_VX;
      end else if (busy) begin
        if (op == ST_POS) begin
          res.x <= sat_coord((COORD_W+1)'(x2) + (COORD_W+1)'(pos.x));
          res.y <= sat_coord((COORD_W+1)'(y3) + (COORD_W+1)'(pos.y));
          res.z <= sat_coord((COORD_W+1)'(z3) + (COORD_W+1)'(pos.z));
          busy  <= 1'b0;
        end else begin
          wb <= !wb;
          if (wb) begin
            op <= step_t'(op + 4'd1);
            case (op)
              ST_VX:   vx  <= mres;
              ST_VY:   vy  <= mres;
              ST_VZ:   vz  <= mres;
              ST_X1:   x1  <= sum_sub;
              ST_Y1:   y1  <= sum_add;
              ST_X2:   x2  <= sum_add;
              ST_Z2:   z2  <= sum_sub;
              ST_Y3:   y3  <= sum_sub;
              ST_Z3:   z3  <= sum_add;
              default: acc <= mres;
            endcase
          end
        end
      end
    end
  end

endmodule

FILE: design/box_corner_transform.sv
// Box corner transform top level: request/config handling, corner cache,
// sequencing of the trig and corner units over one shared multiplier.
// Depends on bct_pkg, bct_if, bct_mul, bct_trig, bct_xform.
//
//  channel | dir | payload                                   | accepted when
//  req     | in  | pos, angle, scale (x/y/z)                  | valid && ready
//  corner  | out | corner_index, out_x/y/z, from_cache, last  | valid && ready
//  cfg     | in  | index (0..5 box min/max), data             | valid && ready
//
// Cache hit: the item goes straight to the emit phase and the eight stored
//   corners leave in order, one per cycle while the consumer is ready. Miss:
//   the trig unit runs ten Taylor steps per angle (multiply, reciprocal
//   multiply, fix-up), then the corner unit forms fifteen products per corner
//   on the same single multiplier; all eight are stored before any leaves.
// Reset is synchronous; it clears control state and the cache valid flag.
// The corner register decouples the output: a stalled consumer only holds the
//   emit phase, and a new item is taken while the last corner waits.
module box_corner_transform (
  input  logic      clk,
  input  logic      rst,
  bct_in_if.sink    req,
  bct_out_if.source corner,
  bct_cfg_if.sink   cfg
);
  import bct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_TRIG, S_XFORM, S_EMIT} state_t;

  state_t state;

  // configuration
  coord_t box_min_x, box_min_y, box_min_z;
  coord_t box_max_x, box_max_y, box_max_z;

  // cache
  angle_t cached_angle_x, cached_angle_y, cached_angle_z;
  logic   cache_valid;
  coord_t corner_store_x [N_CORNERS];
  coord_t corner_store_y [N_CORNERS];
  coord_t corner_store_z [N_CORNERS];

  // captured item
  vec_t   pos_r, scale_r;
  angle_t ang_x, ang_y, ang_z;
  trig_t  rot_x, rot_y, rot_z;

  logic              hit_r;
  logic [1:0]        axis;
  logic [CIDX_W-1:0] cidx;
  logic [CIDX_W-1:0] eidx;
  logic              trig_start, xf_start;

  // output register
  logic              o_valid;
  logic [CIDX_W-1:0] o_idx;
  coord_t            o_x, o_y, o_z;
  logic              o_cache, o_last;

  logic              accept;
  logic              hit;
  logic              out_free;
  angle_t            trig_angle;
  vec_t              box_sel;
  logic              trig_done, xf_done;
  trig_t             trig_res;
  vec_t              xf_res;
  logic [MUL_W-1:0]  trig_a, trig_b, xf_a, xf_b, mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign hit       = cache_valid && req.angle_x == cached_angle_x &&
                     req.angle_y == cached_angle_y && req.angle_z == cached_angle_z;
  assign out_free  = !o_valid || corner.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    case (axis)
      2'd0:    trig_angle = ang_x;
      2'd1:    trig_angle = ang_y;
      default: trig_angle = ang_z;
    endcase
  end

  // corner bit 0 picks max x, bit 1 max z, bit 2 min y
  assign box_sel.x = cidx[0] ? box_max_x : box_min_x;
  assign box_sel.y = cidx[2] ? box_min_y : box_max_y;
  assign box_sel.z = cidx[1] ? box_max_z : box_min_z;

  // one multiplier, owned by whichever unit is running
  assign mul_a = (state == S_TRIG) ? trig_a : xf_a;
  assign mul_b = (state == S_TRIG) ? trig_b : xf_b;

  bct_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  bct_trig u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (trig_angle),
    .done  (trig_done),
    .res   (trig_res),
    .mul_a (trig_a),
    .mul_b (trig_b),
    .prod  (prod)
  );

  bct_xform u_xform (
    .clk   (clk),
    .rst   (rst),
    .start (xf_start),
    .box   (box_sel),
    .scale (scale_r),
    .pos   (pos_r),
    .rot_x (rot_x),
    .rot_y (rot_y),
    .rot_z (rot_z),
    .done  (xf_done),
    .res   (xf_res),
    .mul_a (xf_a),
    .mul_b (xf_b),
    .prod  (prod)
  );

  // box registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0; box_min_y <= '0; box_min_z <= '0;
      box_max_x <= '0; box_max_y <= '0; box_max_z <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_BOX_MIN_X: box_min_x <= cfg.data;
        CFG_BOX_MIN_Y: box_min_y <= cfg.data;
        CFG_BOX_MIN_Z: box_min_z <= cfg.data;
        CFG_BOX_MAX_X: box_max_x <= cfg.data;
        CFG_BOX_MAX_Y: box_max_y <= cfg.data;
        CFG_BOX_MAX_Z: box_max_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // item capture, trig results and the corner store
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r.x   <= req.pos_x;
      pos_r.y   <= req.pos_y;
      pos_r.z   <= req.pos_z;
      scale_r.x <= req.scale_x;
      scale_r.y <= req.scale_y;
      scale_r.z <= req.scale_z;
      ang_x     <= req.angle_x;
      ang_y     <= req.angle_y;
      ang_z     <= req.angle_z;
    end
    if (state == S_TRIG && trig_done) begin
      case (axis)
        2'd0:    rot_x <= trig_res;
        2'd1:    rot_y <= trig_res;
        default: rot_z <= trig_res;
      endcase
    end
    if (state == S_XFORM && xf_done) begin
      corner_store_x[cidx] <= xf_res.x;
      corner_store_y[cidx] <= xf_res.y;
      corner_store_z[cidx] <= xf_res.z;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cache_valid    <= 1'b0;
      cached_angle_x <= '0;
      cached_angle_y <= '0;
      cached_angle_z <= '0;
      hit_r          <= 1'b0;
      axis           <= '0;
      cidx           <= '0;
      eidx           <= '0;
      trig_start     <= 1'b0;
      xf_start       <= 1'b0;
      o_valid        <= 1'b0;
    end else begin
      // start pulses: first angle on a miss, next angle, first and next corner
      trig_start <= (state == S_IDLE && accept && !hit) ||
                    (state == S_TRIG && trig_done && axis != 2'd2);
      xf_start   <= (state == S_TRIG && trig_done && axis == 2'd2) ||
                    (state == S_XFORM && xf_done && cidx != CIDX_W'(N_CORNERS - 1));
      // outside the emit phase a taken corner just empties the register
      if (o_valid && corner.ready && state != S_EMIT) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            hit_r <= hit;
            eidx  <= '0;
            if (hit) begin
              state <= S_EMIT;
            end else begin
              axis  <= '0;
              state <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          if (trig_done) begin
            if (axis == 2'd2) begin
              cidx  <= '0;
              state <= S_XFORM;
            end else begin
              axis <= axis + 2'd1;
            end
          end
        end
        S_XFORM: begin
          if (xf_done) begin
            if (cidx == CIDX_W'(N_CORNERS - 1)) begin
              cached_angle_x <= ang_x;
              cached_angle_y <= ang_y;
              cached_angle_z <= ang_z;
              cache_valid    <= 1'b1;
              state          <= S_EMIT;
            end else begin
              cidx <= cidx + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_idx   <= eidx;
            o_x     <= corner_store_x[eidx];
            o_y     <= corner_store_y[eidx];
            o_z     <= corner_store_z[eidx];
            o_cache <= hit_r;
            o_last  <= (eidx == CIDX_W'(N_CORNERS - 1));
            eidx    <= eidx + 1'b1;
            if (eidx == CIDX_W'(N_CORNERS - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign corner.valid        = o_valid;
  assign corner.corner_index = o_idx;
  assign corner.out_x        = o_x;
  assign corner.out_y        = o_y;
  assign corner.out_z        = o_z;
  assign corner.from_cache   = o_cache;
  assign corner.last_corner  = o_last;

`ifndef NO_ASSERTIONS
  a_hit_skips_compute: assert property (@(posedge clk) disable iff (rst)
    (accept && hit) |=> (state == S_EMIT && hit_r))
    else $error("cache hit did not go straight to emit");

  a_cache_stays_valid: assert property (@(posedge clk) disable iff (rst)
    cache_valid |=> cache_valid)
    else $error("cache valid dropped without reset");

  a_trig_done_in_trig: assert property (@(posedge clk) disable iff (rst)
    trig_done |-> state == S_TRIG)
    else $error("trig unit finished outside the trig phase");

  a_last_is_seven: assert property (@(posedge clk) disable iff (rst)
    (corner.valid && corner.last_corner) |-> corner.corner_index == 3'd7)
    else $error("last corner flag on wrong corner");
`endif

endmodule

FILE: verif/bct_checker.sv
// Scoreboard for box_corner_transform: watches the request, config and corner
// channels, predicts all eight corners per request and compares them in order.
// Depends on bct_pkg and bct_if.
module bct_checker (
  input  logic clk,
  input  logic rst,
  bct_in_if    req,
  bct_out_if   corner,
  bct_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  import bct_pkg::*;

  typedef struct {
    logic [2:0] idx;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic       hit;
    logic       last;
  } corner_exp_t;

  localparam longint unsigned ONE_Q30 = 64'd1 << TRIG_FRAC;

  corner_exp_t corner_q[$];

  longint box_min[3];
  longint box_max[3];
  angle_t last_ax, last_ay, last_az;
  logic   have_cache;
  longint store_x[N_CORNERS];
  longint store_y[N_CORNERS];
  longint store_z[N_CORNERS];

  function automatic longint clamp(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact product, magnitude truncated by sh, clamped to the coord range
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic neg;
    longint unsigned ua, ub, r, cap;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    r = (ua * ub) >> sh;
    cap = (64'd1 << (COORD_W - 1)) - (neg ? 64'd0 : 64'd1);
    if (r > cap) r = cap;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Q2.30 sine/cosine of a binary angle
  task automatic sin_cos(input angle_t a, output longint s, output longint c);
    longint unsigned f, x, x2, t, sv, cv, term;
    logic [1:0] q;
    q = a[ANGLE_W-1 -: 2];
    f = a[ANGLE_FRAC-1:0];
    x = (f * 64'(HALF_PI_Q30)) >> ANGLE_FRAC;
    x2 = (x * x) >> TRIG_FRAC;
    t = ONE_Q30;
    for (int i = 0; i < N_TERMS; i++)
      t = ONE_Q30 - ((x2 * t) >> TRIG_FRAC) / 64'(SIN_DIV[i]);
    sv = (x * t) >> TRIG_FRAC;
    if (sv > ONE_Q30) sv = ONE_Q30;
    t = ONE_Q30;
    for (int i = 0; i < N_TERMS; i++)
      t = ONE_Q30 - ((x2 * t) >> TRIG_FRAC) / 64'(COS_DIV[i]);
    term = ((x2 * t) >> TRIG_FRAC) / 2;
    cv = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    case (q)
      2'd0: begin s = sv;  c = cv;  end
      2'd1: begin s = cv;  c = -longint'(sv); end
      2'd2: begin s = -longint'(sv); c = -longint'(cv); end
      default: begin s = -longint'(cv); c = sv; end
    endcase
  endtask

  task automatic transform_corners();
    longint px, py, pz, kx, ky, kz;
    longint sx, cx, sy, cy, sz, cz;
    longint bx, by, bz, vx, vy, vz, x1, y1, x2, z2, y3, z3;
    px = req.pos_x;   py = req.pos_y;   pz = req.pos_z;
    kx = req.scale_x; ky = req.scale_y; kz = req.scale_z;
    sin_cos(req.angle_x, sx, cx);
    sin_cos(req.angle_y, sy, cy);
    sin_cos(req.angle_z, sz, cz);
    for (int i = 0; i < N_CORNERS; i++) begin
      // bit 0 picks max x, bit 1 max z, bit 2 min y
      bx = i[0] ? box_max[0] : box_min[0];
      by = i[2] ? box_min[1] : box_max[1];
      bz = i[1] ? box_max[2] : box_min[2];
      vx = fx_mul(bx, kx, COORD_FRAC);
      vy = fx_mul(by, ky, COORD_FRAC);
      vz = fx_mul(bz, kz, COORD_FRAC);
      x1 = clamp(fx_mul(vx, cz, TRIG_FRAC) - fx_mul(vy, sz, TRIG_FRAC));
      y1 = clamp(fx_mul(vx, sz, TRIG_FRAC) + fx_mul(vy, cz, TRIG_FRAC));
      x2 = clamp(fx_mul(x1, cy, TRIG_FRAC) + fx_mul(vz, sy, TRIG_FRAC));
      z2 = clamp(fx_mul(vz, cy, TRIG_FRAC) - fx_mul(x1, sy, TRIG_FRAC));
      y3 = clamp(fx_mul(y1, cx, TRIG_FRAC) - fx_mul(z2, sx, TRIG_FRAC));
      z3 = clamp(fx_mul(y1, sx, TRIG_FRAC) + fx_mul(z2, cx, TRIG_FRAC));
      store_x[i] = clamp(x2 + px);
      store_y[i] = clamp(y3 + py);
      store_z[i] = clamp(z3 + pz);
    end
  endtask

  task automatic check_corner();
    corner_exp_t e;
    logic bad;
    if (corner_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected corner idx=%0d x=%h y=%h z=%h",
                 corner.corner_index, corner.out_x, corner.out_y, corner.out_z);
      return;
    end
    e = corner_q.pop_front();
    bad = corner.corner_index !== e.idx || corner.out_x !== e.x ||
          corner.out_y !== e.y || corner.out_z !== e.z ||
          corner.from_cache !== e.hit || corner.last_corner !== e.last;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"ERROR: corner exp idx=%0d x=%h y=%h z=%h hit=%b last=%b",
                  " / got idx=%0d x=%h y=%h z=%h hit=%b last=%b"},
                 e.idx, e.x, e.y, e.z, e.hit, e.last, corner.corner_index,
                 corner.out_x, corner.out_y, corner.out_z, corner.from_cache,
                 corner.last_corner);
    end
  endtask

  always @(posedge clk) begin
    corner_exp_t e;
    logic hit;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i] = 0;
        box_max[i] = 0;
      end
      last_ax = '0; last_ay = '0; last_az = '0;
      have_cache = 1'b0;
      corner_q.delete();
      errors = 0;
    end else begin
      if (corner.valid && corner.ready) check_corner();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BOX_MIN_X: box_min[0] = cfg.data;
          CFG_BOX_MIN_Y: box_min[1] = cfg.data;
          CFG_BOX_MIN_Z: box_min[2] = cfg.data;
          CFG_BOX_MAX_X: box_max[0] = cfg.data;
          CFG_BOX_MAX_Y: box_max[1] = cfg.data;
          CFG_BOX_MAX_Z: box_max[2] = cfg.data;
          default: ;  // unused index, write dropped
        endcase
      end
      if (req.valid && req.ready) begin
        hit = have_cache && req.angle_x == last_ax && req.angle_y == last_ay &&
              req.angle_z == last_az;
        if (!hit) begin
          transform_corners();
          last_ax = req.angle_x; last_ay = req.angle_y; last_az = req.angle_z;
          have_cache = 1'b1;
        end
        for (int i = 0; i < N_CORNERS; i++) begin
          e.idx  = i[2:0];
          e.x    = coord_t'(store_x[i]);
          e.y    = coord_t'(store_y[i]);
          e.z    = coord_t'(store_z[i]);
          e.hit  = hit;
          e.last = (i == N_CORNERS - 1);
          corner_q.push_back(e);
        end
      end
    end
    pending = corner_q.size();
  end

endmodule

FILE: verif/tb_box_corner_transform.sv
// Testbench top for box_corner_transform: clock, reset, request and config
// stimulus, consumer back-pressure and the verdict. Depends on bct_pkg,
// bct_if, the design and bct_checker.
module tb_box_corner_transform;
  import bct_pkg::*;

  // indexes that map to no register
  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

  localparam coord_t Q_ONE  = 32'sh0001_0000;
  localparam coord_t C_MAX  = 32'sh7fff_ffff;
  localparam coord_t C_MIN  = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;

  // idle percentages, changed per phase
  int send_idle  = 0;
  int recv_stall = 0;

  // recently used angle triples, reused to hit the corner cache
  angle_t pool_ax[4];
  angle_t pool_ay[4];
  angle_t pool_az[4];

  bct_in_if  req();
  bct_out_if corner();
  bct_cfg_if cfg();

  box_corner_transform DUT (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .corner (corner),
    .cfg    (cfg)
  );

  bct_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .corner  (corner),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always #1 clk = ~clk;

  // consumer back-pressure
  always @(posedge clk) begin
    if (rst) begin
      corner.ready <= 1'b0;
    end else begin
      corner.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Present one request; valid stays high after acceptance so back-to-back
  // items keep it asserted. Random gaps drop it first.
  task automatic send_item(input coord_t px, input coord_t py, input coord_t pz,
                           input angle_t ax, input angle_t ay, input angle_t az,
                           input coord_t kx, input coord_t ky, input coord_t kz);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.pos_x   <= px;  req.pos_y   <= py;  req.pos_z   <= pz;
    req.angle_x <= ax;  req.angle_y <= ay;  req.angle_z <= az;
    req.scale_x <= kx;  req.scale_y <= ky;  req.scale_z <= kz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // stop sending and let every outstanding corner come out
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while the block is drained
  task automatic write_reg(input cfg_idx_t idx, input coord_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_box(input coord_t nx, input coord_t ny, input coord_t nz,
                           input coord_t xx, input coord_t xy, input coord_t xz);
    write_reg(CFG_BOX_MIN_X, nx);
    write_reg(CFG_BOX_MIN_Y, ny);
    write_reg(CFG_BOX_MIN_Z, nz);
    write_reg(CFG_BOX_MAX_X, xx);
    write_reg(CFG_BOX_MAX_Y, xy);
    write_reg(CFG_BOX_MAX_Z, xz);
  endtask

  // mostly bounded coords (within 2, 8 or 512 units), sometimes the full range
  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
      2:       return coord_t'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      default: return coord_t'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  task automatic send_random();
    int     slot;
    angle_t ax, ay, az;
    slot = $urandom_range(3);
    if ($urandom_range(99) < 55) begin
      ax = pool_ax[slot]; ay = pool_ay[slot]; az = pool_az[slot];
    end else begin
      ax = angle_t'($urandom); ay = angle_t'($urandom); az = angle_t'($urandom);
      pool_ax[slot] = ax; pool_ay[slot] = ay; pool_az[slot] = az;
    end
    send_item(rand_coord(), rand_coord(), rand_coord(), ax, ay, az,
              rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    req.valid = 1'b0;
    req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
    req.angle_x = '0; req.angle_y = '0; req.angle_z = '0;
    req.scale_x = '0; req.scale_y = '0; req.scale_z = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_BOX_MIN_X;
    cfg.data  = '0;
    for (int i = 0; i < 4; i++) begin
      pool_ax[i] = angle_t'($urandom);
      pool_ay[i] = angle_t'($urandom);
      pool_az[i] = angle_t'($urandom);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // reset box is all zero: corners collapse onto the position
    send_item(Q_ONE, -Q_ONE, 32'sh0000_8000, '0, '0, '0, Q_ONE, Q_ONE, Q_ONE);
    drain();
    // plain box, asymmetric so every corner differs
    write_box(-Q_ONE, -2 * Q_ONE, -32'sh0000_8000,
              32'sh0001_8000, 2 * Q_ONE, 3 * Q_ONE);
    send_item('0, '0, '0, 16'h0000, 16'h0000, 16'h0000, Q_ONE, Q_ONE, Q_ONE);
    // same angles, new position: stored corners come back unchanged
    send_item(5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE, 16'h0000, 16'h0000, 16'h0000,
              2 * Q_ONE, Q_ONE, Q_ONE);
    // quadrant edges on each axis
    send_item('0, '0, '0, 16'h4000, 16'h0000, 16'h0000, Q_ONE, Q_ONE, Q_ONE);
    send_item('0, '0, '0, 16'h0000, 16'h8000, 16'h0000, Q_ONE, Q_ONE, Q_ONE);
    send_item('0, '0, '0, 16'h0000, 16'h0000, 16'hc000, Q_ONE, Q_ONE, Q_ONE);
    send_item('0, '0, '0, 16'hffff, 16'hffff, 16'hffff, Q_ONE, Q_ONE, Q_ONE);
    send_item(Q_ONE, Q_ONE, Q_ONE, 16'h2000, 16'h6000, 16'ha000, Q_ONE, -Q_ONE, Q_ONE);
    send_item(Q_ONE, Q_ONE, Q_ONE, 16'h3fff, 16'h7fff, 16'hbfff, Q_ONE, Q_ONE, -Q_ONE);
    // overflow: saturation at every stage
    send_item(C_MAX, C_MAX, C_MAX, 16'h1234, 16'h0000, 16'h0000, C_MAX, C_MAX, C_MAX);
    send_item(C_MIN, C_MIN, C_MIN, 16'h1235, 16'h4321, 16'h0777, C_MIN, C_MIN, C_MIN);
    send_item(C_MAX, C_MIN, '0, 16'h8001, 16'h0001, 16'hffff, C_MIN, C_MAX, '0);
    drain();
    // register writes while cached leave the cache valid; spare indexes ignored
    write_box(-3 * Q_ONE, -3 * Q_ONE, -3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE);
    write_reg(CFG_SPARE_6, C_MAX);
    write_reg(CFG_SPARE_7, C_MIN);
    send_item('0, '0, '0, 16'h8001, 16'h0001, 16'hffff, Q_ONE, Q_ONE, Q_ONE);
    send_item('0, '0, '0, 16'h8002, 16'h0001, 16'hffff, Q_ONE, Q_ONE, Q_ONE);
    drain();
    // inverted box, no swap
    write_box(2 * Q_ONE, Q_ONE, 4 * Q_ONE, -2 * Q_ONE, -Q_ONE, -Q_ONE);
    send_item(Q_ONE, '0, -Q_ONE, 16'h1000, 16'h2000, 16'h3000, Q_ONE, 2 * Q_ONE, Q_ONE);
    drain();
    // extreme box
    write_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_item('0, '0, '0, 16'h1000, 16'h2000, 16'h3001, Q_ONE, Q_ONE, Q_ONE);
    send_item('0, '0, '0, 16'h5555, 16'haaaa, 16'h0f0f, 32'sh0000_0001, C_MAX, -Q_ONE);
    drain();

    // ---- random part: four idling phases, new box before each ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      if (ph == 3)
        write_box(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
      else
        write_box(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      for (int n = 0; n < 52; n++) begin
        send_random();
        // occasionally hold off until all corners are out
        if (n % 20 == 19) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run guard
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
